>>> hdl/wras_pkg.sv
package wras_pkg;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_APPEND = 3'd2,
    KIND_RANK   = 3'd3,
    KIND_ACCESS = 3'd4,
    KIND_SELECT = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOLETTER = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOOCC    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALPHA,
    S_TEXT,
    S_OUT
  } state_e;

  localparam int unsigned KindW   = 3;
  localparam int unsigned SymW    = 8;
  localparam int unsigned PosW    = 12;
  localparam int unsigned OccW    = 13;
  localparam int unsigned ValueW  = 13;
  localparam int unsigned StatusW = 3;

  // text capacity, tied to the position field width
  localparam int unsigned TextMax = 4096;

endpackage

>>> hdl/wras_ram.sv
module wras_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // single write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/wavelet_rank_access_select_core.sv
// Wavelet rank / access / select engine.
// Input stream (s_axis_*): one command per transfer; tuser carries the kind
// (clear, add letter, append symbol, rank, access, select), tdata the symbol,
// position and occurrence. Output stream (m_axis_*): one result per command,
// tdata holds value (13 bits) and status (3 bits).
// Append, rank and select first scan the alphabet store, one entry a cycle,
// through a single shared compare unit; clear, add and access skip that
// scan. Rank and select then scan the text store one symbol a cycle through
// the same comparator; access reads one entry. The read port of each RAM
// sets the pace. One command is worked on at a time, s_axis_tready is low
// until the result has been handed over.
// Reset empties the alphabet and the text (counts cleared, no memory sweep).
// A stalled receiver holds the result in the output register and the block
// takes no new command until that transfer completes.
module wavelet_rank_access_select_core #(
  parameter int unsigned ALPHA_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // symbol[7:0], position[19:8], occurrence[32:20]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // value[12:0], status[15:13]
);
  import wras_pkg::*;

  localparam int unsigned TAW = $clog2(TextMax);
  localparam int unsigned AAW = $clog2(ALPHA_MAX);
  localparam int unsigned TCW = $clog2(TextMax + 1);
  localparam int unsigned ACW = $clog2(ALPHA_MAX + 1);
  localparam int unsigned SW  = (TCW > ValueW) ? TCW : ValueW;

  state_e state_q, state_d;
  logic [KindW-1:0] kind_q;
  logic [SymW-1:0]  sym_q;
  logic [PosW-1:0]  pos_q;
  logic [OccW-1:0]  occ_q;
  logic [ACW-1:0]   acnt_q, acnt_d;
  logic [TCW-1:0]   tcnt_q, tcnt_d;
  logic [TCW-1:0]   idx_q, idx_d;       // scan index issued to the RAM
  logic             rv_q, rv_d;         // read data valid next cycle
  logic [TCW-1:0]   ridx_q, ridx_d;     // index belonging to read data
  logic             found_q, found_d;
  logic [SW-1:0]    n_q, n_d;
  logic [ValueW-1:0]  val_q, val_d;
  logic [StatusW-1:0] st_q, st_d;

  logic            a_we, t_we;
  logic [SymW-1:0] a_rdata, t_rdata;
  logic [AAW-1:0]  a_raddr;
  logic [TAW-1:0]  t_raddr;
  logic            eq;

  wras_ram #(.Width(SymW), .Depth(ALPHA_MAX)) u_alpha (
    .clk_i, .we_i(a_we), .waddr_i(acnt_q[AAW-1:0]), .wdata_i(sym_q),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  wras_ram #(.Width(SymW), .Depth(TextMax)) u_text (
    .clk_i, .we_i(t_we), .waddr_i(tcnt_q[TAW-1:0]), .wdata_i(sym_q),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  assign a_raddr = idx_q[AAW-1:0];
  assign t_raddr = (kind_q == KIND_ACCESS) ? pos_q[TAW-1:0] : idx_q[TAW-1:0];

  // shared comparator
  assign eq = ((state_q == S_ALPHA) ? a_rdata : t_rdata) == sym_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {st_q, val_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acnt_q  <= '0;
      tcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      acnt_q  <= acnt_d;
      tcnt_q  <= tcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      sym_q  <= s_axis_tdata[7:0];
      pos_q  <= s_axis_tdata[19:8];
      occ_q  <= s_axis_tdata[32:20];
    end
    idx_q   <= idx_d;
    rv_q    <= rv_d;
    ridx_q  <= ridx_d;
    found_q <= found_d;
    n_q     <= n_d;
    val_q   <= val_d;
    st_q    <= st_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    acnt_d  = acnt_q;
    tcnt_d  = tcnt_q;
    idx_d   = idx_q;
    rv_d    = 1'b0;
    ridx_d  = idx_q;
    found_d = found_q;
    n_d     = n_q;
    val_d   = val_q;
    st_d    = st_q;
    a_we    = 1'b0;
    t_we    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          idx_d   = '0;
          found_d = 1'b0;
          n_d     = '0;
          val_d   = '0;
          st_d    = ST_OK;
          state_d = S_ALPHA;
        end
      end
      S_ALPHA: begin
        // first check full / trivial kinds, then walk the alphabet
        if (kind_q == KIND_CLEAR) begin
          acnt_d = '0;
          tcnt_d = '0;
          state_d = S_OUT;
        end else if (kind_q == KIND_ADD) begin
          if (acnt_q >= ACW'(ALPHA_MAX)) begin
            st_d = ST_FULL;
          end else begin
            a_we   = 1'b1;
            acnt_d = acnt_q + 1'b1;
          end
          state_d = S_OUT;
        end else if (kind_q == KIND_APPEND && tcnt_q >= TCW'(TextMax)) begin
          st_d = ST_FULL;
          state_d = S_OUT;
        end else if (kind_q == KIND_ACCESS) begin
          if ({1'b0, pos_q} >= (PosW+1)'(tcnt_q)) begin
            st_d = ST_RANGE;
            state_d = S_OUT;
          end else begin
            rv_d = 1'b1;
            state_d = S_TEXT;
          end
        end else if (kind_q != KIND_APPEND && kind_q != KIND_RANK
                     && kind_q != KIND_SELECT) begin
          state_d = S_OUT;
        end else begin
          found_d = found_q | (rv_q & eq);
          if (found_d || (TCW'(idx_q) >= TCW'(acnt_q) && !rv_q)) begin
            if (!found_d) begin
              st_d = ST_NOLETTER;
              state_d = S_OUT;
            end else if (kind_q == KIND_APPEND) begin
              t_we   = 1'b1;
              tcnt_d = tcnt_q + 1'b1;
              state_d = S_OUT;
            end else if (kind_q == KIND_RANK
                         && {1'b0, pos_q} >= (PosW+1)'(tcnt_q)) begin
              st_d = ST_RANGE;
              state_d = S_OUT;
            end else begin
              idx_d = '0;
              state_d = S_TEXT;
            end
          end else if (TCW'(idx_q) < TCW'(acnt_q)) begin
            rv_d  = 1'b1;
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_TEXT: begin
        if (kind_q == KIND_ACCESS) begin
          if (rv_q) begin
            val_d = ValueW'(t_rdata);
            state_d = S_OUT;
          end else begin
            rv_d = 1'b1;
          end
        end else begin
          // one symbol compared per cycle
          if (rv_q && eq) begin
            n_d = n_q + 1'b1;
          end
          if (kind_q == KIND_SELECT && rv_q && eq
              && SW'(occ_q) == n_q + 1'b1) begin
            val_d = ValueW'(ridx_q);
            state_d = S_OUT;
          end else if (idx_q >= tcnt_q
                       || (kind_q == KIND_RANK && idx_q > TCW'(pos_q))) begin
            if (!rv_q) begin
              if (kind_q == KIND_RANK) begin
                val_d = ValueW'(n_d);
              end else begin
                st_d = ST_NOOCC;
              end
              state_d = S_OUT;
            end
          end else begin
            rv_d  = 1'b1;
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> test/tb_wavelet_rank_access_select_core.sv
module tb_wavelet_rank_access_select_core;
  import wras_pkg::*;

  localparam int unsigned AlphaMax = 64;
  // kinds with no function; the block must answer them with ok
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic [12:0] value;
    status_e     status;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // symbol[7:0], position[19:8], occurrence[32:20]
  logic [2:0]  s_axis_tuser = '0;  // kind[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // value[12:0], status[15:13]

  // predictor state
  logic [7:0]  alpha_tab [AlphaMax];
  int unsigned alpha_cnt;
  logic [7:0]  text_mem [TextMax];
  int unsigned text_cnt;

  answer_t     pending_answers[$];
  int unsigned n_errors;
  int unsigned n_items;
  int unsigned n_results;
  bit          stim_done;

  wavelet_rank_access_select_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit letter_known(logic [7:0] sym);
    for (int unsigned i = 0; i < alpha_cnt; i++) begin
      if (alpha_tab[i] == sym) return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected answer for one command, updating the predictor's stores
  function automatic answer_t predict_answer(logic [2:0] kind, logic [7:0] sym,
                                             logic [11:0] pos, logic [12:0] occ);
    answer_t     a;
    int unsigned n;
    a.value  = '0;
    a.status = ST_OK;
    case (kind)
      KIND_CLEAR: begin
        alpha_cnt = 0;
        text_cnt  = 0;
      end
      KIND_ADD: begin
        if (alpha_cnt >= AlphaMax) a.status = ST_FULL;
        else begin
          alpha_tab[alpha_cnt] = sym;
          alpha_cnt++;
        end
      end
      KIND_APPEND: begin
        if (text_cnt >= TextMax) a.status = ST_FULL;
        else if (!letter_known(sym)) a.status = ST_NOLETTER;
        else begin
          text_mem[text_cnt] = sym;
          text_cnt++;
        end
      end
      KIND_RANK: begin
        if (!letter_known(sym)) a.status = ST_NOLETTER;
        else if (pos >= text_cnt) a.status = ST_RANGE;
        else begin
          n = 0;
          for (int unsigned i = 0; i <= pos; i++) if (text_mem[i] == sym) n++;
          a.value = n[12:0];
        end
      end
      KIND_ACCESS: begin
        if (pos >= text_cnt) a.status = ST_RANGE;
        else a.value = {5'd0, text_mem[pos]};
      end
      KIND_SELECT: begin
        if (!letter_known(sym)) a.status = ST_NOLETTER;
        else begin
          a.status = ST_NOOCC;
          n = 0;
          if (occ != 0) begin
            for (int unsigned i = 0; i < text_cnt; i++) begin
              if (text_mem[i] == sym) begin
                n++;
                if (n == occ) begin
                  a.value  = i[12:0];
                  a.status = ST_OK;
                  break;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // one command transfer; valid stays high for a back-to-back follower
  task automatic send_cmd(logic [2:0] kind, logic [7:0] sym = '0,
                          logic [11:0] pos = '0, logic [12:0] occ = '0);
    int unsigned gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, occ, pos, sym};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_answers.push_back(predict_answer(kind, sym, pos, occ));
    n_items++;
  endtask

  // hold the sender off until every answer is back
  task automatic drain_answers();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stall per result, then ready until the transfer
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata[12:0] !== want.value)
          report_mismatch($sformatf("value %0d, want %0d", m_axis_tdata[12:0], want.value));
        if (m_axis_tdata[15:13] !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tdata[15:13], want.status));
      end
    end
  end

  // empty stores, single letter, foreign letters, unordered alphabet, spare kinds
  task automatic test_directed();
    send_cmd(KIND_SPARE6, 8'hFF, 12'hFFF, 13'h1FFF);
    send_cmd(KIND_SPARE7);
    send_cmd(KIND_RANK, 8'h00, 12'd0);
    send_cmd(KIND_ACCESS, 8'h00, 12'd0);
    send_cmd(KIND_SELECT, 8'h00, 12'd0, 13'd1);
    send_cmd(KIND_ADD, 8'hFF);
    send_cmd(KIND_RANK, 8'hFF, 12'd0);
    send_cmd(KIND_APPEND, 8'hFF);
    send_cmd(KIND_APPEND, 8'h00);
    send_cmd(KIND_RANK, 8'hFF, 12'd0);
    send_cmd(KIND_ACCESS, 8'h00, 12'd0);
    send_cmd(KIND_SELECT, 8'hFF, 12'd0, 13'd0);
    send_cmd(KIND_SELECT, 8'hFF, 12'd0, 13'd1);
    send_cmd(KIND_SELECT, 8'hFF, 12'd0, 13'd2);
    // descending and repeated letters
    send_cmd(KIND_ADD, 8'h10);
    send_cmd(KIND_ADD, 8'h10);
    send_cmd(KIND_ADD, 8'h00);
    send_cmd(KIND_APPEND, 8'h00);
    send_cmd(KIND_APPEND, 8'h10);
    send_cmd(KIND_RANK, 8'h00, 12'd2);
    send_cmd(KIND_ACCESS, 8'h00, 12'hFFF);
    send_cmd(KIND_SELECT, 8'h00, 12'd0, 13'h1FFF);
    send_cmd(KIND_RANK, 8'h10, 12'hFFF);
    send_cmd(KIND_CLEAR);
    send_cmd(KIND_ACCESS, 8'h00, 12'd0);
  endtask

  task automatic test_alphabet_full();
    send_cmd(KIND_CLEAR);
    for (int unsigned i = 0; i < AlphaMax; i++) send_cmd(KIND_ADD, 8'(i * 4 + 3));
    send_cmd(KIND_ADD, 8'h01);
    send_cmd(KIND_APPEND, 8'h01);
    send_cmd(KIND_APPEND, 8'(4 * (AlphaMax - 1) + 3));
    send_cmd(KIND_SELECT, 8'(4 * (AlphaMax - 1) + 3), 12'd0, 13'd1);
    drain_answers();
  endtask

  task automatic test_random(int unsigned count);
    int unsigned done;
    int unsigned r;
    logic [7:0]  sym;
    logic [11:0] pos;
    logic [12:0] occ;
    done = 0;
    send_cmd(KIND_CLEAR);
    for (int unsigned i = 0; i < 4; i++) send_cmd(KIND_ADD, 8'($urandom));
    while (done < count) begin
      r   = $urandom_range(0, 99);
      sym = 8'($urandom);
      if (alpha_cnt > 0 && $urandom_range(0, 9) < 8)
        sym = alpha_tab[$urandom_range(0, alpha_cnt - 1)];
      pos = 12'($urandom_range(0, text_cnt + 2));
      if ($urandom_range(0, 9) == 0) pos = 12'($urandom);
      occ = 13'($urandom_range(0, 8));
      if ($urandom_range(0, 9) == 0) occ = 13'($urandom);
      if (r < 2) begin
        send_cmd(KIND_CLEAR);
      end else if (r < 9) begin
        send_cmd(KIND_ADD, 8'($urandom));
      end else if (r < 36) begin
        send_cmd(KIND_APPEND, sym);
      end else if (r < 56) begin
        send_cmd(KIND_RANK, sym, pos, occ);
      end else if (r < 71) begin
        send_cmd(KIND_ACCESS, sym, pos, occ);
      end else if (r < 93) begin
        send_cmd(KIND_SELECT, sym, pos, occ);
      end else begin
        send_cmd(r[0] ? KIND_SPARE7 : KIND_SPARE6, sym, pos, occ);
        continue;
      end
      done++;
    end
  endtask

  initial begin
    n_errors  = 0;
    n_items   = 0;
    n_results = 0;
    stim_done = 1'b0;
    alpha_cnt = 0;
    text_cnt  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_alphabet_full();
    test_random(40);
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (pending_answers.size() != 0) report_mismatch("answers never arrived");
    $display("covered: spare kinds, empty and single-letter stores, unordered letters,");
    $display("full alphabet, random loads and queries: %0d commands, %0d results",
             n_items, n_results);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60000000;
    $display("timeout, stimulus finished: %0d", stim_done);
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
hdl/wras_pkg.sv
hdl/wras_ram.sv
hdl/wavelet_rank_access_select_core.sv
test/tb_wavelet_rank_access_select_core.sv
